@@ rtl/core/adsf_pkg.sv @@
package adsf_pkg;

   localparam int CONV_WIDTH   = 12;
   localparam int SAMPLE_WIDTH = 12;
   localparam int WORD_WIDTH   = 16;

   localparam int DECIMATION_DEF    = 8;
   localparam int TAPS_DEF          = 6;
   localparam int FRAME_SAMPLES_DEF = 64;

   localparam logic [WORD_WIDTH-1:0] HEADER_WORD   = 16'hFFFF;
   localparam logic [7:0]            LOW_BYTE_FULL = 8'hFF;

   // The result queue must be a power of two deep; one sample can push two beats.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int BURST_MAX       = 2;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word;
      logic                  is_header;
      logic                  last;
   } rsp_entry_type;

   typedef struct packed {
      logic       valid;
      logic       frame_end;
      sample_type avg;
   } smooth_push_type;

endpackage

@@ rtl/core/adsf_req_if.sv @@
interface adsf_req_if import adsf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CONV_WIDTH-1:0] conversion;

   modport source (output valid, output conversion, input ready);
   modport sink (input valid, input conversion, output ready);
endinterface

@@ rtl/core/adsf_rsp_if.sv @@
interface adsf_rsp_if import adsf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] word;
   logic                  is_header;
   logic                  last;

   modport source (output valid, output word, output is_header, output last, input ready);
   modport sink (input valid, input word, input is_header, input last, output ready);
endinterface

@@ rtl/core/adsf_smoother.sv @@
module adsf_smoother import adsf_pkg::*; #(
   parameter int TAPS          = TAPS_DEF,
   parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  sample_type      in_sample,
   output smooth_push_type push
);

   localparam int HistDepth   = TAPS - 1;
   localparam int SumWidth    = SAMPLE_WIDTH + $clog2(TAPS);
   localparam int AvgShift    = SumWidth + $clog2(TAPS);
   localparam int MulWidth    = SumWidth + 1;
   localparam int ProdWidth   = SumWidth + MulWidth;
   localparam longint AvgMul  = ((longint'(1) << AvgShift) + longint'(TAPS) - 1) / longint'(TAPS);
   localparam int FrameWidth  = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
   localparam logic [FrameWidth-1:0] FrameLast = FrameWidth'(FRAME_SAMPLES - 1);

   logic [HistDepth-1:0][SAMPLE_WIDTH-1:0] hist_ff, hist_in;
   logic [SumWidth-1:0]                    hist_sum_ff, hist_sum_in;
   logic [FrameWidth-1:0]                  frame_ff, frame_in;
   logic [SumWidth-1:0]                    window_sum;
   logic [ProdWidth-1:0]                   avg_product;
   logic                                   frame_end;

   // The running sum of the history avoids a long adder chain over the taps.
   assign window_sum  = hist_sum_ff + SumWidth'(in_sample);
   assign hist_sum_in = window_sum - SumWidth'(hist_ff[0]);

   // Division by the tap count as a reciprocal multiply, exact over the sum's range.
   assign avg_product = ProdWidth'(window_sum) * ProdWidth'(AvgMul);

   for (genvar i = 0; i < HistDepth; i++) begin : g_hist
      if (i == HistDepth - 1) begin : g_newest
         assign hist_in[i] = in_sample;
      end else begin : g_older
         assign hist_in[i] = hist_ff[i + 1];
      end
   end

   assign frame_end = frame_ff == FrameLast;
   assign frame_in  = frame_end ? '0 : frame_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         hist_sum_ff <= '0;
         frame_ff    <= '0;
      end else if (in_valid) begin
         hist_ff     <= hist_in;
         hist_sum_ff <= hist_sum_in;
         frame_ff    <= frame_in;
      end
   end

   assign push.valid     = in_valid;
   assign push.frame_end = frame_end;
   assign push.avg       = avg_product[AvgShift +: SAMPLE_WIDTH];

endmodule

@@ rtl/core/adsf_rsp_queue.sv @@
module adsf_rsp_queue import adsf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  smooth_push_type            push,
   input  logic                       pop_ready,
   output logic                       head_valid,
   output rsp_entry_type              head,
   output logic [QUEUE_CNT_WIDTH-1:0] count
);

   rsp_entry_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, wr_next;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic [QUEUE_CNT_WIDTH-1:0]   push_count;
   rsp_entry_type                entry_sample, entry_header;
   logic                         pop;

   assign entry_sample = '{word: WORD_WIDTH'(push.avg), is_header: 1'b0, last: !push.frame_end};
   assign entry_header = '{word: HEADER_WORD, is_header: 1'b1, last: 1'b1};

   assign push_count = !push.valid ? '0 :
                       push.frame_end ? QUEUE_CNT_WIDTH'(2) : QUEUE_CNT_WIDTH'(1);

   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign pop        = head_valid && pop_ready;

   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_WIDTH'(push_count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_WIDTH'(pop);
   assign count_in  = count_ff + push_count - QUEUE_CNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= entry_sample;
      end
      if (push.valid && push.frame_end) begin
         mem_ff[wr_next] <= entry_header;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/adc_decimate_smooth_framer_top.sv @@
// Throughput: one conversion beat per cycle, sustained while results are drained.
// Timing: the beat that closes a decimation group is registered as a sample at the edge
// that takes it; its smoothed beat is offered from the next edge on, and at a frame end
// the header beat follows directly behind it.
// Reset is synchronous and active high: it clears the group position, accumulator,
// smoothing history, frame count and result queue.
module adc_decimate_smooth_framer_top import adsf_pkg::*; #(
   parameter int DECIMATION    = DECIMATION_DEF,
   parameter int TAPS          = TAPS_DEF,
   parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   adsf_req_if.sink   req_chan,
   adsf_rsp_if.source rsp_chan
);

   localparam int IndexWidth = $clog2(2 * DECIMATION);
   localparam int AccWidth   = CONV_WIDTH + $clog2(DECIMATION);
   localparam int DecShift   = AccWidth + $clog2(DECIMATION);
   localparam int MulWidth   = AccWidth + 1;
   localparam int ProdWidth  = AccWidth + MulWidth;
   localparam longint DecMul =
      ((longint'(1) << DecShift) + longint'(DECIMATION) - 1) / longint'(DECIMATION);
   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(2 * DECIMATION - 1);
   localparam int HeadWidth = QUEUE_CNT_WIDTH + 1;

   logic [IndexWidth-1:0]      index_ff, index_in;
   logic [AccWidth-1:0]        acc_ff, acc_in;
   logic                       s1_valid_ff, s1_valid_in;
   sample_type                 s1_sample_ff;
   logic [ProdWidth-1:0]       dec_product;
   sample_type                 dec_quot, dec_fixed;
   logic                       req_accept, group_end;
   smooth_push_type            push;
   rsp_entry_type              head;
   logic                       head_valid;
   logic [QUEUE_CNT_WIDTH-1:0] queue_count;

   // Room is reserved for the sample in flight as well as for this beat's own pair.
   assign req_chan.ready = HeadWidth'(queue_count) +
                           (s1_valid_ff ? HeadWidth'(BURST_MAX) : HeadWidth'(0))
                           <= HeadWidth'(QUEUE_DEPTH - BURST_MAX);

   assign req_accept = req_chan.valid && req_chan.ready;
   assign group_end  = index_ff == LastIndex;

   always_comb begin
      index_in = index_ff;
      acc_in   = acc_ff;
      if (req_accept) begin
         if (group_end) begin
            index_in = '0;
            acc_in   = '0;
         end else begin
            index_in = index_ff + 1'b1;
            if (!index_ff[0]) begin
               acc_in = acc_ff + AccWidth'(req_chan.conversion);
            end
         end
      end
   end

   // The closing beat sits at an odd position, so the accumulator already holds the group sum.
   assign dec_product = ProdWidth'(acc_ff) * ProdWidth'(DecMul);
   assign dec_quot    = dec_product[DecShift +: SAMPLE_WIDTH];
   assign dec_fixed   = (dec_quot[7:0] == LOW_BYTE_FULL) ? dec_quot - 1'b1 : dec_quot;
   assign s1_valid_in = req_accept && group_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= '0;
         acc_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         index_ff    <= index_in;
         acc_ff      <= acc_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_sample_ff <= dec_fixed;
      end
   end

   adsf_smoother #(
      .TAPS          (TAPS),
      .FRAME_SAMPLES (FRAME_SAMPLES)
   ) u_smoother (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_sample (s1_sample_ff),
      .push      (push)
   );

   adsf_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_chan.ready),
      .head_valid (head_valid),
      .head       (head),
      .count      (queue_count)
   );

   assign rsp_chan.valid     = head_valid;
   assign rsp_chan.word      = head.word;
   assign rsp_chan.is_header = head.is_header;
   assign rsp_chan.last      = head.last;

endmodule

@@ rtl/core/adsf_checker.sv @@
module adsf_checker import adsf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [WORD_WIDTH-1:0] rsp_word,
   input logic                  rsp_is_header,
   input logic                  rsp_last
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) &&
                                  $stable(rsp_is_header) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // A header beat always carries the header word and closes its burst.
   a_header_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_header |-> rsp_word == HEADER_WORD && rsp_last)
      else $error("malformed header beat");

   // A sample beat that is not last is followed at once by its header.
   a_header_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_header && !rsp_last |=> rsp_valid && rsp_is_header)
      else $error("frame-end sample not followed by header");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind adc_decimate_smooth_framer_top adsf_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_word      (rsp_chan.word),
   .rsp_is_header (rsp_chan.is_header),
   .rsp_last      (rsp_chan.last)
);
